// File: src/mpet_pkg.sv
// package: constants, codes and command types of the escape-time block
`default_nettype none
package mpet_pkg;

  localparam int unsigned MAX_LIMBS_DEFAULT = 8;
  localparam int unsigned LIMB_BITS         = 32;
  localparam int unsigned INT_BITS          = 4;
  localparam int unsigned ITER_W            = 16;
  localparam int unsigned LIMBS_CFG_W       = 4;
  localparam int unsigned CFG_IDX_W         = 1;
  localparam int unsigned CFG_DATA_W        = 16;
  localparam int unsigned ESC_BIT           = LIMB_BITS - 2 * (INT_BITS - 1);
  localparam int unsigned ESC_HIGH_W        = LIMB_BITS - ESC_BIT + 1;

  localparam logic [ITER_W-1:0]      ITER_LIMIT_RST = 16'd256;
  localparam logic [LIMBS_CFG_W-1:0] LIMBS_RST      = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ITER_LIMIT   = 1'b0,
    REG_LIMBS_IN_USE = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLR,
    OP_LATCH,
    OP_MUL,
    OP_CARRY,
    OP_EXT,
    OP_CMP,
    OP_ADD,
    OP_FIN
  } op_e;

  typedef enum logic [2:0] {
    SEL_RR,
    SEL_II,
    SEL_RI,
    SEL_SI,
    SEL_SD,
    SEL_SR
  } sel_e;

  typedef enum logic [1:0] {
    CMP_EQ,
    CMP_GT,
    CMP_LT
  } cmp_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_CHECK,
    ST_LATCH,
    ST_MUL,
    ST_CARRY,
    ST_EXT,
    ST_DRAIN,
    ST_DECIDE,
    ST_CMP,
    ST_ADD,
    ST_FIN,
    ST_DONE
  } ctl_state_e;

  typedef struct packed {
    op_e  op;
    sel_e sel;
    logic first;
    logic row0;
    logic hi;
    logic top;
  } cmd_t;

  typedef struct packed {
    logic we;
    logic last;
  } ld_ctl_t;

  typedef struct packed {
    logic escaped;
  } stat_t;

endpackage
`default_nettype wire

// File: src/mpet_item_if.sv
// interface: input item channel carrying one limb pair of c
`default_nettype none
interface mpet_item_if;
  logic                           valid;
  logic                           ready;
  logic [mpet_pkg::LIMB_BITS-1:0] c_real_limb;
  logic [mpet_pkg::LIMB_BITS-1:0] c_imag_limb;
  logic                           c_real_negative;
  logic                           c_imag_negative;
  logic                           last_limb;

  modport source (
    output valid, c_real_limb, c_imag_limb, c_real_negative, c_imag_negative, last_limb,
    input  ready
  );
  modport sink (
    input  valid, c_real_limb, c_imag_limb, c_real_negative, c_imag_negative, last_limb,
    output ready
  );
endinterface
`default_nettype wire

// File: src/mpet_result_if.sv
// interface: result item channel carrying the escape count
`default_nettype none
interface mpet_result_if;
  logic                        valid;
  logic                        ready;
  logic [mpet_pkg::ITER_W-1:0] iteration_count;
  logic                        escaped;

  modport source (
    output valid, iteration_count, escaped,
    input  ready
  );
  modport sink (
    input  valid, iteration_count, escaped,
    output ready
  );
endinterface
`default_nettype wire

// File: src/mpet_ram.sv
// generic single write port ram with registered read
`default_nettype none
module mpet_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 8,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// File: src/mpet_datapath.sv
// datapath: limb stores, shared multiply-accumulate and signed limb adder
`default_nettype none
module mpet_datapath #(
  parameter  int unsigned MAX_LIMBS = mpet_pkg::MAX_LIMBS_DEFAULT,
  localparam int unsigned LW = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1,
  localparam int unsigned FW = $clog2(2 * MAX_LIMBS),
  localparam int unsigned NW = $clog2(MAX_LIMBS + 1)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire mpet_pkg::cmd_t                 cmd_i,
  input  wire logic [FW-1:0]                  idx_i,
  input  wire logic [LW-1:0]                  row_i,
  input  wire logic [NW-1:0]                  limbs_i,
  input  wire mpet_pkg::ld_ctl_t              ld_i,
  input  wire logic [LW-1:0]                  ld_idx_i,
  input  wire logic [mpet_pkg::LIMB_BITS-1:0] real_limb_i,
  input  wire logic [mpet_pkg::LIMB_BITS-1:0] imag_limb_i,
  input  wire logic                           real_neg_i,
  input  wire logic                           imag_neg_i,
  output mpet_pkg::stat_t                     stat_o
);
  import mpet_pkg::*;

  localparam int unsigned LB = LIMB_BITS;

  cmd_t          cmd_q;
  logic [FW-1:0] idx_q;
  logic [LW-1:0] row_q;

  logic [LB-1:0] cr_rd, ci_rd, zr_rd, zi_rd, sqr_rd, sqi_rd, tp_rd, fa_rd, fb_rd;
  logic [LB-1:0] a_rd, b_rd, acc_rd;
  logic [LW-1:0] lidx, lidx_q, ext_w;
  logic [FW-1:0] full_raddr, acc_waddr, ext_diff;

  logic [LB-1:0]   ai_q, carry_q, pa_q, pb_q;
  logic [2*LB-1:0] prod, mac;
  logic [LB-1:0]   ext_a, ext_b, tp_val, acc_wdata;
  logic            dbl_q, ecy_q, lnz_q, lnz_in, esc_q, esc_now;
  logic [LB:0]     esum;
  logic [ESC_HIGH_W-1:0] high;

  cmp_e          cmp_q, cmp_d;
  logic          ac_q, nz_q, sa, sb, same, ge, cin;
  logic [LB:0]   alu;
  logic [LB-1:0] big, small_op;
  logic          rneg;
  logic          cr_neg_q, ci_neg_q, zr_neg_q, zi_neg_q, diff_neg_q;

  logic zr_we, zi_we, sqr_we, sqi_we, tp_we, fa_we, fb_we;
  logic [LW-1:0] sqr_waddr;
  logic [LB-1:0] zr_wdata, zi_wdata, sqr_wdata;

  // issue side addresses
  assign lidx       = idx_i[LW-1:0];
  assign full_raddr = (cmd_i.op == OP_MUL) ? (FW'(row_i) + idx_i) : idx_i;

  // execute side addresses
  assign lidx_q    = idx_q[LW-1:0];
  assign acc_waddr = FW'(row_q) + idx_q;
  assign ext_diff  = idx_q - FW'(limbs_i);
  assign ext_w     = ext_diff[LW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= '0;
    end else begin
      cmd_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_i;
    row_q <= row_i;
  end

  always_comb begin
    case (cmd_q.sel)
      SEL_RR:  begin a_rd = zr_rd;  b_rd = zr_rd;  acc_rd = fa_rd; end
      SEL_II:  begin a_rd = zi_rd;  b_rd = zi_rd;  acc_rd = fb_rd; end
      SEL_RI:  begin a_rd = zr_rd;  b_rd = zi_rd;  acc_rd = fb_rd; end
      SEL_SI:  begin a_rd = tp_rd;  b_rd = ci_rd;  acc_rd = fb_rd; end
      SEL_SD:  begin a_rd = sqr_rd; b_rd = sqi_rd; acc_rd = fb_rd; end
      SEL_SR:  begin a_rd = sqr_rd; b_rd = cr_rd;  acc_rd = fb_rd; end
      default: begin a_rd = '0;     b_rd = '0;     acc_rd = '0;    end
    endcase
  end

  // multiply-accumulate of one limb pair
  assign prod = ai_q * b_rd;
  assign mac  = prod + (2*LB)'(cmd_q.row0 ? '0 : acc_rd)
                     + (2*LB)'(cmd_q.first ? '0 : carry_q);
  assign acc_wdata = (cmd_q.op == OP_MUL) ? mac[LB-1:0] : carry_q;

  // realignment of full products and escape sum
  assign ext_a   = {fa_rd[LB-INT_BITS-1:0], pa_q[LB-1 -: INT_BITS]};
  assign ext_b   = {fb_rd[LB-INT_BITS-1:0], pb_q[LB-1 -: INT_BITS]};
  assign tp_val  = {ext_b[LB-2:0], dbl_q};
  assign esum    = {1'b0, fa_rd} + {1'b0, fb_rd} + (LB+1)'(cmd_q.first ? 1'b0 : ecy_q);
  assign high    = {esum[LB], esum[LB-1:ESC_BIT]};
  assign lnz_in  = cmd_q.first ? 1'b0 : lnz_q;
  assign esc_now = (high > ESC_HIGH_W'(1)) ||
                   ((high == ESC_HIGH_W'(1)) && (lnz_in || (esum[ESC_BIT-1:0] != '0)));

  // signed magnitude limb adder
  always_comb begin
    case (cmd_q.sel)
      SEL_SI:  begin sa = zr_neg_q ^ zi_neg_q; sb = ci_neg_q; end
      SEL_SD:  begin sa = 1'b0;                sb = 1'b1;     end
      SEL_SR:  begin sa = diff_neg_q;          sb = cr_neg_q; end
      default: begin sa = 1'b0;                sb = 1'b0;     end
    endcase
    same     = (sa == sb);
    ge       = (cmp_q != CMP_LT);
    cin      = cmd_q.first ? 1'b0 : ac_q;
    big      = ge ? a_rd : b_rd;
    small_op = ge ? b_rd : a_rd;
    if (same) begin
      alu = {1'b0, a_rd} + {1'b0, b_rd} + (LB+1)'(cin);
    end else begin
      alu = {1'b0, big} - {1'b0, small_op} - (LB+1)'(cin);
    end
    rneg = nz_q & (same ? sa : (ge ? sa : sb));
    if (a_rd != b_rd) begin
      cmp_d = (a_rd > b_rd) ? CMP_GT : CMP_LT;
    end else begin
      cmp_d = cmd_q.first ? CMP_EQ : cmp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_q.op)
      OP_LATCH: ai_q <= a_rd;
      OP_MUL:   carry_q <= mac[2*LB-1:LB];
      OP_EXT: begin
        pa_q  <= fa_rd;
        pb_q  <= fb_rd;
        ecy_q <= esum[LB];
        lnz_q <= lnz_in | (esum[LB-1:0] != '0);
        if (cmd_q.first) begin
          dbl_q <= 1'b0;
        end else if (cmd_q.hi) begin
          dbl_q <= ext_b[LB-1];
        end
      end
      OP_CMP: cmp_q <= cmp_d;
      OP_ADD: begin
        ac_q <= alu[LB];
        nz_q <= (cmd_q.first ? 1'b0 : nz_q) | (alu[LB-1:0] != '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q      <= 1'b0;
      cr_neg_q   <= 1'b0;
      ci_neg_q   <= 1'b0;
      zr_neg_q   <= 1'b0;
      zi_neg_q   <= 1'b0;
      diff_neg_q <= 1'b0;
    end else begin
      if (ld_i.last) begin
        cr_neg_q <= real_neg_i;
        ci_neg_q <= imag_neg_i;
        zr_neg_q <= 1'b0;
        zi_neg_q <= 1'b0;
      end
      if (cmd_q.op == OP_EXT && cmd_q.sel == SEL_II && cmd_q.top) begin
        esc_q <= esc_now;
      end
      if (cmd_q.op == OP_FIN) begin
        case (cmd_q.sel)
          SEL_SI:  zi_neg_q   <= rneg;
          SEL_SD:  diff_neg_q <= rneg;
          SEL_SR:  zr_neg_q   <= rneg;
          default: ;
        endcase
      end
    end
  end

  assign stat_o.escaped = esc_q;

  // store write ports
  always_comb begin
    zr_we     = (cmd_q.op == OP_CLR) || (cmd_q.op == OP_ADD && cmd_q.sel == SEL_SR);
    zi_we     = (cmd_q.op == OP_CLR) || (cmd_q.op == OP_ADD && cmd_q.sel == SEL_SI);
    zr_wdata  = (cmd_q.op == OP_CLR) ? '0 : alu[LB-1:0];
    zi_wdata  = zr_wdata;
    sqi_we    = (cmd_q.op == OP_EXT) && (cmd_q.sel == SEL_II) && cmd_q.hi;
    tp_we     = (cmd_q.op == OP_EXT) && (cmd_q.sel == SEL_RI) && cmd_q.hi;
    sqr_we    = sqi_we || (cmd_q.op == OP_ADD && cmd_q.sel == SEL_SD);
    sqr_waddr = (cmd_q.op == OP_EXT) ? ext_w : lidx_q;
    sqr_wdata = (cmd_q.op == OP_EXT) ? ext_a : alu[LB-1:0];
    fa_we     = (cmd_q.op == OP_MUL || cmd_q.op == OP_CARRY) && (cmd_q.sel == SEL_RR);
    fb_we     = (cmd_q.op == OP_MUL || cmd_q.op == OP_CARRY) &&
                (cmd_q.sel == SEL_II || cmd_q.sel == SEL_RI);
  end

  mpet_ram #(.WIDTH(LB), .DEPTH(MAX_LIMBS)) u_c_real (
    .clk_i, .we_i(ld_i.we), .waddr_i(ld_idx_i), .wdata_i(real_limb_i),
    .raddr_i(lidx), .rdata_o(cr_rd)
  );
  mpet_ram #(.WIDTH(LB), .DEPTH(MAX_LIMBS)) u_c_imag (
    .clk_i, .we_i(ld_i.we), .waddr_i(ld_idx_i), .wdata_i(imag_limb_i),
    .raddr_i(lidx), .rdata_o(ci_rd)
  );
  mpet_ram #(.WIDTH(LB), .DEPTH(MAX_LIMBS)) u_z_real (
    .clk_i, .we_i(zr_we), .waddr_i(lidx_q), .wdata_i(zr_wdata),
    .raddr_i(lidx), .rdata_o(zr_rd)
  );
  mpet_ram #(.WIDTH(LB), .DEPTH(MAX_LIMBS)) u_z_imag (
    .clk_i, .we_i(zi_we), .waddr_i(lidx_q), .wdata_i(zi_wdata),
    .raddr_i(lidx), .rdata_o(zi_rd)
  );
  mpet_ram #(.WIDTH(LB), .DEPTH(MAX_LIMBS)) u_sq_real (
    .clk_i, .we_i(sqr_we), .waddr_i(sqr_waddr), .wdata_i(sqr_wdata),
    .raddr_i(lidx), .rdata_o(sqr_rd)
  );
  mpet_ram #(.WIDTH(LB), .DEPTH(MAX_LIMBS)) u_sq_imag (
    .clk_i, .we_i(sqi_we), .waddr_i(ext_w), .wdata_i(ext_b),
    .raddr_i(lidx), .rdata_o(sqi_rd)
  );
  mpet_ram #(.WIDTH(LB), .DEPTH(MAX_LIMBS)) u_twice (
    .clk_i, .we_i(tp_we), .waddr_i(ext_w), .wdata_i(tp_val),
    .raddr_i(lidx), .rdata_o(tp_rd)
  );
  mpet_ram #(.WIDTH(LB), .DEPTH(2 * MAX_LIMBS)) u_full_a (
    .clk_i, .we_i(fa_we), .waddr_i(acc_waddr), .wdata_i(acc_wdata),
    .raddr_i(full_raddr), .rdata_o(fa_rd)
  );
  mpet_ram #(.WIDTH(LB), .DEPTH(2 * MAX_LIMBS)) u_full_b (
    .clk_i, .we_i(fb_we), .waddr_i(acc_waddr), .wdata_i(acc_wdata),
    .raddr_i(full_raddr), .rdata_o(fb_rd)
  );
endmodule
`default_nettype wire

// File: src/mpet_ctrl.sv
// controller: limb loading, step sequencing, config registers and result register
`default_nettype none
module mpet_ctrl #(
  parameter  int unsigned MAX_LIMBS = mpet_pkg::MAX_LIMBS_DEFAULT,
  localparam int unsigned LW = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1,
  localparam int unsigned FW = $clog2(2 * MAX_LIMBS),
  localparam int unsigned NW = $clog2(MAX_LIMBS + 1)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [mpet_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mpet_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                            in_valid_i,
  input  wire logic                            in_last_i,
  output logic                                 in_ready_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [mpet_pkg::ITER_W-1:0]          count_o,
  output logic                                 escaped_o,
  output mpet_pkg::cmd_t                       cmd_o,
  output logic [FW-1:0]                        idx_o,
  output logic [LW-1:0]                        row_o,
  output logic [NW-1:0]                        limbs_o,
  output mpet_pkg::ld_ctl_t                    ld_o,
  output logic [LW-1:0]                        ld_idx_o,
  input  wire mpet_pkg::stat_t                 stat_i
);
  import mpet_pkg::*;

  localparam int unsigned CW = (NW > LIMBS_CFG_W) ? NW : LIMBS_CFG_W;

  ctl_state_e state_q, state_d;
  logic [ITER_W-1:0]      limit_q;
  logic [LIMBS_CFG_W-1:0] lim_q;
  logic [NW-1:0] cnt_q, cnt_d, n_q, n_d, n_eff;
  logic [LW-1:0] i_q, i_d, i_end;
  logic [FW-1:0] k_q, k_d, k_end, k2_end;
  logic [NW:0]   two_n_m1;
  logic [CW-1:0] lim_ext;
  sel_e          sel_q, sel_d;
  logic [ITER_W-1:0] step_q, step_d, count_q, count_d;
  logic out_valid_q, out_valid_d, esc_q, esc_d, fin_esc_q, fin_esc_d;

  assign lim_ext  = CW'(lim_q);
  assign two_n_m1 = {n_q, 1'b0} - (NW+1)'(1);
  assign k_end    = FW'(n_q - NW'(1));
  assign k2_end   = FW'(two_n_m1);
  assign i_end    = LW'(n_q - NW'(1));

  always_comb begin
    if (lim_ext == '0) begin
      n_eff = NW'(1);
    end else if (lim_ext > CW'(MAX_LIMBS)) begin
      n_eff = NW'(MAX_LIMBS);
    end else begin
      n_eff = NW'(lim_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= ITER_LIMIT_RST;
      lim_q   <= LIMBS_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ITER_LIMIT:   limit_q <= cfg_wdata_i[ITER_W-1:0];
        REG_LIMBS_IN_USE: lim_q   <= cfg_wdata_i[LIMBS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      n_q         <= NW'(1);
      i_q         <= '0;
      k_q         <= '0;
      sel_q       <= SEL_RR;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      fin_esc_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      i_q         <= i_d;
      k_q         <= k_d;
      sel_q       <= sel_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      fin_esc_q   <= fin_esc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
    esc_q   <= esc_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    i_d         = i_q;
    k_d         = k_q;
    sel_d       = sel_q;
    step_d      = step_q;
    fin_esc_d   = fin_esc_q;
    out_valid_d = out_valid_q;
    count_d     = count_q;
    esc_d       = esc_q;
    in_ready_o  = 1'b0;
    ld_o        = '0;
    cmd_o       = '0;
    cmd_o.op    = OP_NOP;
    cmd_o.sel   = sel_q;
    idx_o       = k_q;
    row_o       = i_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ld_o.we = (cnt_q < NW'(MAX_LIMBS));
          if (in_last_i) begin
            ld_o.last = 1'b1;
            cnt_d     = '0;
            n_d       = n_eff;
            k_d       = '0;
            step_d    = '0;
            state_d   = ST_CLR;
          end else if (cnt_q < NW'(MAX_LIMBS)) begin
            cnt_d = cnt_q + NW'(1);
          end
        end
      end
      ST_CLR: begin
        cmd_o.op = OP_CLR;
        if (k_q == k_end) begin
          k_d     = '0;
          state_d = ST_CHECK;
        end else begin
          k_d = k_q + FW'(1);
        end
      end
      ST_CHECK: begin
        if (step_q >= limit_q) begin
          fin_esc_d = 1'b0;
          state_d   = ST_DONE;
        end else begin
          sel_d   = SEL_RR;
          i_d     = '0;
          k_d     = '0;
          state_d = ST_LATCH;
        end
      end
      ST_LATCH: begin
        cmd_o.op = OP_LATCH;
        idx_o    = FW'(i_q);
        k_d      = '0;
        state_d  = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.op    = OP_MUL;
        cmd_o.first = (k_q == '0);
        cmd_o.row0  = (i_q == '0);
        if (k_q == k_end) begin
          state_d = ST_CARRY;
        end else begin
          k_d = k_q + FW'(1);
        end
      end
      ST_CARRY: begin
        cmd_o.op = OP_CARRY;
        idx_o    = FW'(n_q);
        k_d      = '0;
        if (i_q == i_end) begin
          i_d = '0;
          if (sel_q == SEL_RR) begin
            sel_d   = SEL_II;
            state_d = ST_LATCH;
          end else begin
            state_d = ST_EXT;
          end
        end else begin
          i_d     = i_q + LW'(1);
          state_d = ST_LATCH;
        end
      end
      ST_EXT: begin
        cmd_o.op    = OP_EXT;
        cmd_o.first = (k_q == '0);
        cmd_o.hi    = (k_q >= FW'(n_q));
        cmd_o.top   = (k_q == k2_end);
        if (k_q == k2_end) begin
          k_d     = '0;
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + FW'(1);
        end
      end
      ST_DRAIN: state_d = ST_DECIDE;
      ST_DECIDE: begin
        k_d = '0;
        i_d = '0;
        if (sel_q == SEL_II) begin
          if (stat_i.escaped) begin
            fin_esc_d = 1'b1;
            state_d   = ST_DONE;
          end else begin
            sel_d   = SEL_RI;
            state_d = ST_LATCH;
          end
        end else begin
          sel_d   = SEL_SI;
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd_o.op    = OP_CMP;
        cmd_o.first = (k_q == '0);
        if (k_q == k_end) begin
          k_d     = '0;
          state_d = ST_ADD;
        end else begin
          k_d = k_q + FW'(1);
        end
      end
      ST_ADD: begin
        cmd_o.op    = OP_ADD;
        cmd_o.first = (k_q == '0);
        if (k_q == k_end) begin
          k_d     = '0;
          state_d = ST_FIN;
        end else begin
          k_d = k_q + FW'(1);
        end
      end
      ST_FIN: begin
        cmd_o.op = OP_FIN;
        case (sel_q)
          SEL_SI: begin
            sel_d   = SEL_SD;
            state_d = ST_CMP;
          end
          SEL_SD: begin
            sel_d   = SEL_SR;
            state_d = ST_CMP;
          end
          default: begin
            step_d  = step_q + ITER_W'(1);
            state_d = ST_CHECK;
          end
        endcase
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          count_d     = step_q;
          esc_d       = fin_esc_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign ld_idx_o    = cnt_q[LW-1:0];
  assign limbs_o     = n_q;
  assign out_valid_o = out_valid_q;
  assign count_o     = count_q;
  assign escaped_o   = esc_q;
endmodule
`default_nettype wire

// File: src/multiprecision_escape_time.sv
// top level: multi-limb fixed point escape-time unit
// limbs load one per cycle while the unit is idle; the item with last_limb starts the point
// each step of n limbs runs its three limb products in turn
// through the one 32x32 multiply-accumulate
// a point first clears z limb by limb, then steps until escape or the limit
// reset clears control state and restores iteration_limit 256 and limbs_in_use 8
`default_nettype none
module multiprecision_escape_time #(
  parameter int unsigned MAX_LIMBS = mpet_pkg::MAX_LIMBS_DEFAULT
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [mpet_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mpet_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  mpet_item_if.sink                            item_if,
  mpet_result_if.source                        result_if
);
  import mpet_pkg::*;

  localparam int unsigned LW = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;
  localparam int unsigned FW = $clog2(2 * MAX_LIMBS);
  localparam int unsigned NW = $clog2(MAX_LIMBS + 1);

  cmd_t          cmd;
  stat_t         stat;
  ld_ctl_t       ld;
  logic [FW-1:0] idx;
  logic [LW-1:0] row, ld_idx;
  logic [NW-1:0] limbs;

  mpet_ctrl #(.MAX_LIMBS(MAX_LIMBS)) u_ctrl (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i  (item_if.valid),
    .in_last_i   (item_if.last_limb),
    .in_ready_o  (item_if.ready),
    .out_valid_o (result_if.valid),
    .out_ready_i (result_if.ready),
    .count_o     (result_if.iteration_count),
    .escaped_o   (result_if.escaped),
    .cmd_o       (cmd),
    .idx_o       (idx),
    .row_o       (row),
    .limbs_o     (limbs),
    .ld_o        (ld),
    .ld_idx_o    (ld_idx),
    .stat_i      (stat)
  );

  mpet_datapath #(.MAX_LIMBS(MAX_LIMBS)) u_datapath (
    .clk_i,
    .rst_ni,
    .cmd_i       (cmd),
    .idx_i       (idx),
    .row_i       (row),
    .limbs_i     (limbs),
    .ld_i        (ld),
    .ld_idx_i    (ld_idx),
    .real_limb_i (item_if.c_real_limb),
    .imag_limb_i (item_if.c_imag_limb),
    .real_neg_i  (item_if.c_real_negative),
    .imag_neg_i  (item_if.c_imag_negative),
    .stat_o      (stat)
  );
endmodule
`default_nettype wire
